[rtl/box_average_downscaler_unit_defines.svh]
// Assertion macros used by the downscaler back part.
// Each macro expects signals named clock and reset in the using module.
`ifndef BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define BADU_ASSERT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define BADU_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

[rtl/badu_pkg.sv]
// Package for the box average downscaler: widths, register indexes, command type.
// No dependencies.
`timescale 1ns / 1ps
package badu_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_BPP   = 8;
   localparam int DEF_MAX_RATIO = 64;

   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 16;
   localparam int BPP_W     = 4;
   localparam int RATIO_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int PIX_W     = 14;
   localparam int SUM_W     = 22;
   localparam int IDX_MAX_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUO_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP          = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO        = 2'd3;

   // One byte of work handed from the front to the back.
   typedef struct packed {
      logic [IDX_MAX_W-1:0] idx;
      logic [BYTE_W-1:0]    sample;
      logic                 first;
      logic                 last;
      logic                 done;
      logic [PIX_W-1:0]     pixels;
   } cmd_type;

endpackage

[rtl/box_average_downscaler_unit.sv]
// Box average downscaler: one result byte per averaging square and channel.
// An accepted byte passes through sum memory read and write in the back part; a byte that closes
// a square then goes through a bit-serial divider and the result register, which can stall.
// The back part takes a new byte only when it has finished the last one, set by the
// read-modify-write of the sum memory and any division.
// Synchronous active-high reset restores sizes 1 and all positions; the sum memory is not cleared.
`timescale 1ns / 1ps
module box_average_downscaler_unit
   import badu_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BPP   = DEF_MAX_BPP,
   parameter int MAX_RATIO = DEF_MAX_RATIO
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  push,
   output logic                  full,
   input  logic [BYTE_W-1:0]     req_sample_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic [BYTE_W-1:0]     rsp_average_byte,
   output logic                  rsp_image_done
);

   cmd_type front_cmd, back_cmd;
   logic    q_push, q_full, q_pop, q_empty;

   // Front part: counters and command generation.
   badu_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BPP   (MAX_BPP),
      .MAX_RATIO (MAX_RATIO)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (push),
      .req_full        (full),
      .req_sample_byte (req_sample_byte),
      .cmd_push        (q_push),
      .cmd_full        (q_full),
      .cmd             (front_cmd)
   );

   // Queue decoupling the two parts.
   badu_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (back_cmd),
      .empty     (q_empty)
   );

   // Back part: accumulation and division.
   badu_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BPP   (MAX_BPP)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (q_empty),
      .cmd_pop          (q_pop),
      .cmd              (back_cmd),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_average_byte (rsp_average_byte),
      .rsp_image_done   (rsp_image_done)
   );

endmodule

[rtl/badu_front.sv]
// Front part: configuration registers, position counters and command generation.
// Depends on badu_pkg.
`timescale 1ns / 1ps
module badu_front
   import badu_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BPP   = DEF_MAX_BPP,
   parameter int MAX_RATIO = DEF_MAX_RATIO
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [BYTE_W-1:0]     req_sample_byte,
   output logic                  cmd_push,
   input  logic                  cmd_full,
   output cmd_type               cmd
);

   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic [BPP_W-1:0]     bpp_ff, bpp_in;
   logic [RATIO_W-1:0]   ratio_ff, ratio_in;
   logic [BPP_W-1:0]     chan_ff, chan_in;
   logic [WIDTH_W-1:0]   col_ff, col_in;
   logic [RATIO_W-1:0]   cis_ff, cis_in;
   logic [HEIGHT_W-1:0]  row_ff, row_in;
   logic [RATIO_W-1:0]   ris_ff, ris_in;
   logic [IDX_MAX_W-1:0] base_ff, base_in;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [BPP_W-1:0]    b_eff;
   logic                enabled, accept, csr_wr;
   logic                last_col, last_row, last_chan, end_col, end_row;
   logic [RATIO_W:0]    cis_n, ris_n;
   logic [2*RATIO_W+1:0] pix_prod;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;

   // Effective sizes after clamping zero values and oversized width and bpp.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      if (bpp_ff == '0) begin
         b_eff = BPP_W'(1);
      end else if (int'(bpp_ff) > MAX_BPP) begin
         b_eff = BPP_W'(MAX_BPP);
      end else begin
         b_eff = bpp_ff;
      end
   end

   assign enabled = (ratio_ff != '0) && (int'(ratio_ff) <= MAX_RATIO)
                    && (int'(ratio_ff) <= int'(w_eff)) && (int'(ratio_ff) <= int'(h_eff));

   // Square and image boundary flags.
   assign last_col  = (int'(cis_ff) + 1 >= int'(ratio_ff)) || (int'(col_ff) + 1 >= int'(w_eff));
   assign last_row  = (int'(ris_ff) + 1 >= int'(ratio_ff)) || (int'(row_ff) + 1 >= int'(h_eff));
   assign last_chan = int'(chan_ff) + 1 >= int'(b_eff);
   assign end_col   = int'(col_ff) + 1 >= int'(w_eff);
   assign end_row   = int'(row_ff) + 1 >= int'(h_eff);
   assign cis_n     = {1'b0, cis_ff} + (RATIO_W+1)'(1);
   assign ris_n     = {1'b0, ris_ff} + (RATIO_W+1)'(1);
   assign pix_prod  = cis_n * ris_n;

   // Command for the back part.
   assign cmd_push    = accept && enabled;
   assign cmd.idx     = base_ff + IDX_MAX_W'(chan_ff);
   assign cmd.sample  = req_sample_byte;
   assign cmd.first   = (cis_ff == '0) && (ris_ff == '0);
   assign cmd.last    = last_col && last_row;
   assign cmd.done    = end_row && end_col && last_chan;
   assign cmd.pixels  = PIX_W'(pix_prod);

   // Configuration writes and position counter advance.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      ratio_in  = ratio_ff;
      chan_in   = chan_ff;
      col_in    = col_ff;
      cis_in    = cis_ff;
      row_in    = row_ff;
      ris_in    = ris_ff;
      base_in   = base_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data[HEIGHT_W-1:0];
            CSR_BPP:          bpp_in    = csr_data[BPP_W-1:0];
            CSR_RATIO:        ratio_in  = csr_data[RATIO_W-1:0];
            default:          width_in  = width_ff;
         endcase
         chan_in = '0;
         col_in  = '0;
         cis_in  = '0;
         row_in  = '0;
         ris_in  = '0;
         base_in = '0;
      end else if (accept) begin
         chan_in = chan_ff + BPP_W'(1);
         if (last_chan) begin
            chan_in = '0;
            if (enabled && !(int'(cis_ff) + 1 >= int'(ratio_ff))) begin
               cis_in = cis_n[RATIO_W-1:0];
            end else begin
               cis_in = '0;
               if (enabled) begin
                  base_in = base_ff + IDX_MAX_W'(b_eff);
               end
            end
            col_in = col_ff + WIDTH_W'(1);
            if (end_col) begin
               col_in  = '0;
               cis_in  = '0;
               base_in = '0;
               if (enabled && !(int'(ris_ff) + 1 >= int'(ratio_ff))) begin
                  ris_in = ris_n[RATIO_W-1:0];
               end else begin
                  ris_in = '0;
               end
               row_in = row_ff + HEIGHT_W'(1);
               if (end_row) begin
                  row_in = '0;
                  ris_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(1);
         height_ff <= HEIGHT_W'(1);
         bpp_ff    <= BPP_W'(1);
         ratio_ff  <= RATIO_W'(1);
         chan_ff   <= '0;
         col_ff    <= '0;
         cis_ff    <= '0;
         row_ff    <= '0;
         ris_ff    <= '0;
         base_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         ratio_ff  <= ratio_in;
         chan_ff   <= chan_in;
         col_ff    <= col_in;
         cis_ff    <= cis_in;
         row_ff    <= row_in;
         ris_ff    <= ris_in;
         base_ff   <= base_in;
      end
   end

endmodule

[rtl/badu_cmd_queue.sv]
// Two-entry command queue between the front and back parts.
// Depends on badu_pkg.
`timescale 1ns / 1ps
module badu_cmd_queue
   import badu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/badu_back.sv]
// Back part: sum memory read-modify-write, bit-serial divider and result register.
// Depends on badu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "box_average_downscaler_unit_defines.svh"
module badu_back
   import badu_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BPP   = DEF_MAX_BPP
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  cmd_type           cmd,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [BYTE_W-1:0] rsp_average_byte,
   output logic              rsp_image_done
);

   localparam int SUM_DEPTH = MAX_WIDTH * MAX_BPP;
   localparam int IDX_W     = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [SUM_W-1:0] sum_mem [SUM_DEPTH];

   logic [1:0]        state_ff, state_in;
   cmd_type           cmd_ff;
   logic [SUM_W-1:0]  rd_data_ff;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [2:0]        step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_done_ff;
   logic [SUM_W-1:0]  new_sum, trial;
   logic              mem_wr, out_load, out_free;

   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty;
   assign new_sum  = cmd_ff.first ? SUM_W'(cmd_ff.sample)
                                  : rd_data_ff + SUM_W'(cmd_ff.sample);
   assign mem_wr   = state_ff == S_ADD;
   assign trial    = SUM_W'(cmd_ff.pixels) << step_ff;
   assign out_free = !out_valid_ff || rsp_pop;
   assign out_load = (state_ff == S_OUT) && out_free;

   // Sum memory: registered read at pop, write in the cycle after.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_data_ff <= sum_mem[cmd.idx[IDX_W-1:0]];
         cmd_ff     <= cmd;
      end
      if (mem_wr) begin
         sum_mem[cmd_ff.idx[IDX_W-1:0]] <= new_sum;
      end
   end

   // Sequencer and restoring divider, one quotient bit per cycle.
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            rem_in   = new_sum;
            quo_in   = '0;
            step_in  = 3'd7;
            state_in = cmd_ff.last ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (rem_ff >= trial) begin
               rem_in          = rem_ff - trial;
               quo_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (out_load) begin
         out_byte_ff <= quo_ff;
         out_done_ff <= cmd_ff.done;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_average_byte = out_byte_ff;
   assign rsp_image_done   = out_done_ff;

   `BADU_ASSERT(a_add_after_idle, state_ff == S_ADD, $past(state_ff) == S_IDLE, "add without pop")
   `BADU_ASSERT_NEXT(a_div_to_out, (state_ff == S_DIV) && (step_ff == 3'd0), state_ff == S_OUT, "divider overran")
   `BADU_ASSERT(a_result_from_out, $rose(out_valid_ff), $past(state_ff) == S_OUT, "result without division")
   `BADU_ASSERT(a_pop_only_idle, cmd_pop, !out_load && !mem_wr, "command popped while busy")

endmodule

[dv/box_average_downscaler_unit_tb.sv]
// Testbench for box_average_downscaler_unit: directed and random image streams
// checked beat by beat against a built-in box-average predictor. Depends on badu_pkg.
`timescale 1ns / 1ps
module box_average_downscaler_unit_tb;
   import badu_pkg::*;

   localparam int SUM_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_BPP;
   localparam int SETTLE       = 40;
   localparam int TARGET_ITEMS = 1450;
   localparam int QUIET_ITEMS  = 1300;

   typedef struct {
      logic [BYTE_W-1:0] average;
      logic              done;
   } average_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  push;
   logic                  full;
   logic [BYTE_W-1:0]     req_sample_byte;
   logic                  empty;
   logic                  pop;
   logic [BYTE_W-1:0]     rsp_average_byte;
   logic                  rsp_image_done;

   // Predictor copy of the registers and position counters.
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;
   logic [BPP_W-1:0]    cfg_bpp;
   logic [RATIO_W-1:0]  cfg_ratio;
   int unsigned channel_pos, column_pos, column_in_square, row_pos, row_in_square;
   int unsigned channel_sums [SUM_DEPTH];

   logic [BYTE_W-1:0] pending_bytes [$];
   average_beat_type  expected_averages [$];
   int  accepted_count;
   int  fail_count;
   int  send_gap;
   int  take_gap;
   bit  hold_results;
   bit  quiet;

   box_average_downscaler_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push            (push),
      .full            (full),
      .req_sample_byte (req_sample_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_average_byte(rsp_average_byte),
      .rsp_image_done  (rsp_image_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Any register write restarts the image.
   function automatic void restart_image();
      channel_pos = 0;
      column_pos = 0;
      column_in_square = 0;
      row_pos = 0;
      row_in_square = 0;
   endfunction

   // Advance the box average over one byte and queue the mean a closed square yields.
   function automatic void predict_average(logic [BYTE_W-1:0] sample);
      int unsigned w, h, b, r, idx, pixels;
      bit enabled, last_col, last_row;
      average_beat_type beat;
      w = (cfg_width == 0) ? 1 : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      b = (cfg_bpp == 0) ? 1 : cfg_bpp;
      r = cfg_ratio;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (b > DEF_MAX_BPP) b = DEF_MAX_BPP;
      enabled = r != 0 && r <= DEF_MAX_RATIO && r <= w && r <= h;
      if (enabled) begin
         idx = (column_pos / r) * b + channel_pos;
         last_col = column_in_square + 1 >= r || column_pos + 1 >= w;
         last_row = row_in_square + 1 >= r || row_pos + 1 >= h;
         if (column_in_square == 0 && row_in_square == 0)
            channel_sums[idx] = sample;
         else
            channel_sums[idx] = channel_sums[idx] + sample;
         if (last_col && last_row) begin
            pixels = (column_in_square + 1) * (row_in_square + 1);
            beat.average = BYTE_W'(channel_sums[idx] / pixels);
            beat.done = row_pos + 1 >= h && column_pos + 1 >= w && channel_pos + 1 >= b;
            expected_averages.push_back(beat);
         end
      end
      channel_pos++;
      if (channel_pos >= b) begin
         channel_pos = 0;
         if (enabled)
            column_in_square = (column_in_square + 1 >= r) ? 0 : column_in_square + 1;
         else
            column_in_square = 0;
         column_pos++;
         if (column_pos >= w) begin
            column_pos = 0;
            column_in_square = 0;
            if (enabled)
               row_in_square = (row_in_square + 1 >= r) ? 0 : row_in_square + 1;
            else
               row_in_square = 0;
            row_pos++;
            if (row_pos >= h) begin
               row_pos = 0;
               row_in_square = 0;
            end
         end
      end
   endfunction

   // Sample driver: takes beats from the pending queue, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         send_gap <= 0;
      end else begin
         if (push && !full) begin
            predict_average(req_sample_byte);
            void'(pending_bytes.pop_front());
            accepted_count <= accepted_count + 1;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            push <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 18);
            push <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            push <= 1'b1;
            req_sample_byte <= pending_bytes[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Result monitor: pops with random stalls and checks each beat in order.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         take_gap <= 0;
      end else begin
         if (pop && !empty) begin
            if (expected_averages.size() == 0) begin
               $error("unexpected result beat: average_byte %0d image_done %0d",
                      rsp_average_byte, rsp_image_done);
               fail_count++;
            end else begin
               if (rsp_average_byte !== expected_averages[0].average) begin
                  $error("average_byte: expected %0d, actual %0d",
                         expected_averages[0].average, rsp_average_byte);
                  fail_count++;
               end
               if (rsp_image_done !== expected_averages[0].done) begin
                  $error("image_done: expected %0d, actual %0d",
                         expected_averages[0].done, rsp_image_done);
                  fail_count++;
               end
               void'(expected_averages.pop_front());
            end
         end
         if (hold_results) begin
            pop <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(0, 18);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Long receiver stall once traffic is flowing, so the block backs up into full.
   initial begin
      hold_results = 1'b0;
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_results <= 1'b1;
      repeat (400) @(posedge clock);
      hold_results <= 1'b0;
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || push || expected_averages.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_IMAGE_WIDTH:  cfg_width = data[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
         CSR_BPP:          cfg_bpp = data[BPP_W-1:0];
         CSR_RATIO:        cfg_ratio = data[RATIO_W-1:0];
         default: ;
      endcase
      restart_image();
      csr_valid <= 1'b0;
   endtask

   // Program one geometry and queue a number of sample beats.
   task automatic run_phase(int w, int h, int b, int r, int count, bit extremes);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_BPP, CSR_DATA_W'(b));
      write_reg(CSR_RATIO, CSR_DATA_W'(r));
      for (int i = 0; i < count; i++) begin
         if (extremes)
            pending_bytes.push_back((i % 2) ? 8'hFF : 8'h00);
         else
            pending_bytes.push_back(BYTE_W'($urandom));
      end
   endtask

   initial begin
      int w, h, b, r, n;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_data = '0;
      req_sample_byte = '0;
      accepted_count = 0;
      fail_count = 0;
      quiet = 1'b0;
      cfg_width = 1;
      cfg_height = 1;
      cfg_bpp = 1;
      cfg_ratio = 1;
      restart_image();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: every byte is its own one-pixel image.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h5A);
      // Extreme and out-of-range register values, extreme sample values, disabled ratios.
      run_phase(4, 3, 2, 3, 24, 1);
      run_phase(0, 0, 0, 1, 2, 0);
      run_phase(4095, 1, 15, 1, 20, 0);
      run_phase(3, 65535, 1, 2, 12, 0);
      run_phase(5, 5, 1, 0, 6, 0);
      run_phase(5, 5, 1, 127, 6, 0);
      run_phase(70, 2, 1, 64, 6, 0);
      run_phase(2, 2, 8, 2, 32, 1);

      // Random geometries: mostly whole images, some cut short, some disabled.
      while (accepted_count + pending_bytes.size() < TARGET_ITEMS) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         b = $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0)
            r = $urandom_range(0, 127);
         else
            r = $urandom_range(1, (w < h) ? w : h);
         n = w * h * b * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, n);
         // The last phase stops at the item budget.
         if (accepted_count + pending_bytes.size() + n > TARGET_ITEMS)
            n = TARGET_ITEMS - accepted_count - pending_bytes.size();
         if (accepted_count > QUIET_ITEMS)
            quiet = 1'b1;
         run_phase(w, h, b, r, n, 0);
      end

      quiet = 1'b1;
      wait_idle();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
